/* design/rotation_matrix_to_quaternion_defines.svh */
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotation matrix to quaternion check failed");

// Next-cycle implication, disabled while reset is high.
`define RMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotation matrix to quaternion check failed");

`endif

/* design/rmq_pkg.sv */
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; used by the front end, queue, divider and top level.
`default_nettype none

package rmq_pkg;

  localparam int DIAG_W = 18;
  localparam int DIFF_W = 17;
  localparam int QUO_W  = 17;
  localparam int NLANES = 3;

  localparam logic [QUO_W-1:0] SAT_POS_MAG = 17'd32767;
  localparam logic [QUO_W-1:0] SAT_NEG_MAG = 17'd32768;
  localparam logic signed [15:0] Q_MAX = 16'sh7fff;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  // Which output component is taken from the square root directly.
  typedef enum logic [1:0] {SLOT_W, SLOT_X, SLOT_Y, SLOT_Z} slot_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_beat_t;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               degenerate;
  } quat_beat_t;

  // A classified matrix: radicand combination, root slot and the three
  // off-diagonal terms in increasing output-slot order.
  typedef struct packed {
    logic                     degenerate;
    slot_t                    slot;
    logic signed [DIAG_W-1:0] diag;
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
  } class_t;

  typedef struct packed {
    logic                     degenerate;
    slot_t                    slot;
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
  } sq_side_t;

  typedef struct packed {
    logic               degenerate;
    slot_t              slot;
    logic signed [15:0] main_val;
  } div_side_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* design/rmq_front.sv */
// Front end: classifies one matrix into radicand, root slot and numerators.
// Depends on rmq_pkg.
`default_nettype none

module rmq_front #(
  parameter int FRAC_BITS = 14
) (
  input  rmq_pkg::mat_beat_t mat,
  output rmq_pkg::class_t    cls
);

  localparam int DW = rmq_pkg::DIAG_W;
  localparam int FW = rmq_pkg::DIFF_W;
  localparam int RW = ((FRAC_BITS > DW - 1) ? FRAC_BITS : DW - 1) + 2;
  localparam logic signed [RW-1:0] ONE_R = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [DW-1:0] a00, a11, a22, tr;
  logic signed [RW-1:0] rad;
  rmq_pkg::slot_t       pick;

  always_comb begin
    a00 = DW'(mat.m00);
    a11 = DW'(mat.m11);
    a22 = DW'(mat.m22);
    tr  = a00 + a11 + a22;

    // Largest diagonal entry; only a strictly greater one displaces it.
    pick = rmq_pkg::SLOT_X;
    if (mat.m11 > mat.m00) begin
      pick = rmq_pkg::SLOT_Y;
    end
    if (mat.m22 > ((pick == rmq_pkg::SLOT_Y) ? mat.m11 : mat.m00)) begin
      pick = rmq_pkg::SLOT_Z;
    end

    if (tr > 0) begin
      cls.slot = rmq_pkg::SLOT_W;
      cls.diag = tr;
      cls.d0   = FW'(mat.m21) - FW'(mat.m12);
      cls.d1   = FW'(mat.m02) - FW'(mat.m20);
      cls.d2   = FW'(mat.m10) - FW'(mat.m01);
    end else begin
      cls.slot = pick;
      unique case (pick)
        rmq_pkg::SLOT_Y: begin
          cls.diag = a11 - a22 - a00;
          cls.d0   = FW'(mat.m02) - FW'(mat.m20);
          cls.d1   = FW'(mat.m01) + FW'(mat.m10);
          cls.d2   = FW'(mat.m21) + FW'(mat.m12);
        end
        rmq_pkg::SLOT_Z: begin
          cls.diag = a22 - a00 - a11;
          cls.d0   = FW'(mat.m10) - FW'(mat.m01);
          cls.d1   = FW'(mat.m02) + FW'(mat.m20);
          cls.d2   = FW'(mat.m12) + FW'(mat.m21);
        end
        default: begin
          cls.diag = a00 - a11 - a22;
          cls.d0   = FW'(mat.m21) - FW'(mat.m12);
          cls.d1   = FW'(mat.m10) + FW'(mat.m01);
          cls.d2   = FW'(mat.m20) + FW'(mat.m02);
        end
      endcase
    end

    rad            = RW'(cls.diag) + ONE_R;
    cls.degenerate = (rad <= 0);
  end

endmodule

`default_nettype wire

/* design/rmq_fifo.sv */
// Short queue of classified matrices between the front and back ends.
// Depends on rmq_pkg.
`default_nettype none

module rmq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rmq_pkg::class_t  din,
  input  logic             pop,
  output rmq_pkg::class_t  dout,
  output rmq_pkg::q_stat_t stat
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  rmq_pkg::class_t ent [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  assign dout       = ent[rd_ptr];
  assign stat.full  = (count == CNTW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

/* design/rmq_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a sideband.
// Depends on nothing but the clock enable given by its user.
`default_nettype none

module rmq_sqrt #(
  parameter int VW     = 32,
  parameter int SIDE_W = 54
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VW-1:0]     in_v,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [VW/2-1:0]   out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int SW  = VW / 2;
  localparam int RMW = SW + 3;

  logic              vld  [SW];
  logic [SW-1:0]     root [SW];
  logic [SIDE_W-1:0] side [SW];
  logic [RMW-1:0]    rem  [SW-1];
  logic [VW-1:0]     vv   [SW-1];

  for (genvar g = 0; g < SW; g++) begin : g_stage
    localparam int P = SW - 1 - g;
    logic              src_vld;
    logic [SW-1:0]     src_root;
    logic [SIDE_W-1:0] src_side;
    logic [RMW-1:0]    src_rem;
    logic [VW-1:0]     src_v;
    logic [RMW-1:0]    rem_sh, trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_root = '0;
      assign src_side = in_side;
      assign src_rem  = '0;
      assign src_v    = in_v;
    end else begin : g_rest
      assign src_vld  = vld[g-1];
      assign src_root = root[g-1];
      assign src_side = side[g-1];
      assign src_rem  = rem[g-1];
      assign src_v    = vv[g-1];
    end

    assign rem_sh = {src_rem[RMW-3:0], src_v[2*P+1 -: 2]};
    assign trial  = {1'b0, src_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[g] <= {src_root[SW-2:0], ge};
        side[g] <= src_side;
      end
    end

    if (g < SW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g] <= ge ? rem_sh - trial : rem_sh;
          vv[g]  <= src_v;
        end
      end
    end
  end

  assign out_valid = vld[SW-1];
  assign out_root  = root[SW-1];
  assign out_side  = side[SW-1];

endmodule

`default_nettype wire

/* design/rmq_div.sv */
// Three-lane pipelined rounding divider with saturation to 16 bits.
// Depends on rmq_pkg.
`default_nettype none

module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int SW        = 16,
  parameter int SIDE_W    = 19
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [SW-1:0]                                in_root,
  input  logic [rmq_pkg::NLANES-1:0][rmq_pkg::DIFF_W-1:0] in_d,
  input  logic [SIDE_W-1:0]                            in_side,
  output logic                                         out_valid,
  output logic [rmq_pkg::NLANES-1:0][15:0]             out_q,
  output logic [SIDE_W-1:0]                            out_side
);

  localparam int DW  = rmq_pkg::DIFF_W;
  localparam int QW  = rmq_pkg::QUO_W;
  localparam int NL  = rmq_pkg::NLANES;
  localparam int NST = QW + 1;
  localparam int NA  = DW + FRAC_BITS;
  localparam int NB  = SW + 1 + QW;
  localparam int CW  = ((NA > NB) ? NA : NB) + 1;

  logic              vld   [NST];
  logic [SIDE_W-1:0] side  [NST];
  logic [QW-1:0]     quo   [NST][NL];
  logic              neg   [NST][NL];
  logic              ovf   [NST][NL];
  logic [CW-1:0]     rem   [NST-1][NL];
  logic [CW-1:0]     den_r [NST-1][NL];

  // Entry stage: numerator (|d| << F) + root, denominator 2 * root.
  for (genvar l = 0; l < NL; l++) begin : g_entry
    logic [DW-1:0] mag;
    logic [CW-1:0] num, den, lim;

    assign mag = in_d[l][DW-1] ? (~in_d[l] + 1'b1) : in_d[l];
    assign num = (CW'(mag) << FRAC_BITS) + CW'(in_root);
    assign den = CW'(in_root) << 1;
    assign lim = den << QW;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0][l]   <= num;
        den_r[0][l] <= den;
        quo[0][l]   <= '0;
        neg[0][l]   <= in_d[l][DW-1];
        ovf[0][l]   <= (num >= lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s < NST; s++) begin : g_stage
    localparam int B = QW - s;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= side[s-1];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [CW-1:0] dsh;
      logic          ge;

      assign dsh = den_r[s-1][l] << B;
      assign ge  = (rem[s-1][l] >= dsh);

      always_ff @(posedge clk) begin
        if (en) begin
          quo[s][l] <= quo[s-1][l] | (QW'(ge) << B);
          neg[s][l] <= neg[s-1][l];
          ovf[s][l] <= ovf[s-1][l];
        end
      end

      if (s < NST - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem[s][l]   <= ge ? rem[s-1][l] - dsh : rem[s-1][l];
            den_r[s][l] <= den_r[s-1][l];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [QW-1:0] q, nq;

    assign q  = quo[NST-1][l];
    assign nq = ~q + 1'b1;
    assign out_q[l] = neg[NST-1][l] ?
        ((ovf[NST-1][l] || q > rmq_pkg::SAT_NEG_MAG) ? rmq_pkg::Q_MIN : nq[15:0]) :
        ((ovf[NST-1][l] || q > rmq_pkg::SAT_POS_MAG) ? rmq_pkg::Q_MAX : q[15:0]);
  end

  assign out_valid = vld[NST-1];
  assign out_side  = side[NST-1];

endmodule

`default_nettype wire

/* design/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion block: front end, queue,
// root and divider pipelines, output register. Depends on rmq_pkg, the four
// rmq_* modules and rotation_matrix_to_quaternion_defines.svh.
//
//   channel  beat type     handshake              direction
//   mat      mat_beat_t    mat_valid / mat_stall  in
//   quat     quat_beat_t   quat_valid / quat_stall out
//
// One matrix may be taken in every cycle and one quaternion leaves in every
// cycle; the rate is set by the back pipeline, which moves as a whole.
// A beat passes through the root pipeline, the divider entry and quotient stages
// and the output register. SW, the root width, is ceil((max(FRAC_BITS, 17) + 1 +
// FRAC_BITS) / 2); the queue read is combinational.
// Reset (synchronous) empties the queue and clears every stage valid bit.
// A stalled output freezes the back pipeline; the queue then fills and
// mat_stall rises once it holds QUEUE_DEPTH beats.
`default_nettype none
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS   = 14,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mat_valid,
  output logic                mat_stall,
  input  rmq_pkg::mat_beat_t  mat,
  output logic                quat_valid,
  input  logic                quat_stall,
  output rmq_pkg::quat_beat_t quat
);

  localparam int DW  = rmq_pkg::DIAG_W;
  localparam int RW  = ((FRAC_BITS > DW - 1) ? FRAC_BITS : DW - 1) + 2;
  localparam int VW0 = RW - 1 + FRAC_BITS;
  localparam int VW  = VW0 + (VW0 % 2);
  localparam int SW  = VW / 2;
  localparam int MW  = (SW > 16) ? SW : 16;
  localparam int SQS = $bits(rmq_pkg::sq_side_t);
  localparam int DVS = $bits(rmq_pkg::div_side_t);
  localparam logic signed [RW-1:0] ONE_R = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;

  rmq_pkg::class_t     cls, head;
  rmq_pkg::q_stat_t    qstat;
  logic                push, pop, back_en;
  logic signed [RW-1:0] rad;
  logic [VW-1:0]       sq_v;
  rmq_pkg::sq_side_t   sq_in, sq_out;
  logic [SQS-1:0]      sq_out_bits;
  logic                sq_valid;
  logic [SW-1:0]       root;
  logic [MW-1:0]       half;
  rmq_pkg::div_side_t  dv_in, dv_out;
  logic [DVS-1:0]      dv_out_bits;
  logic                div_valid;
  logic [rmq_pkg::NLANES-1:0][15:0] lane_q;
  rmq_pkg::quat_beat_t quat_next;

  // Front end: classification happens on the way into the queue.
  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .mat (mat),
    .cls (cls)
  );

  assign mat_stall = qstat.full;
  assign push      = mat_valid && !qstat.full;

  // The back end advances whenever the output register is free or drained.
  assign back_en = !quat_valid || !quat_stall;
  assign pop     = back_en && !qstat.empty;

  rmq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cls),
    .pop  (pop),
    .dout (head),
    .stat (qstat)
  );

  // Radicand in the same format, shifted up so that its root is too.
  // A degenerate beat feeds zero; its result is forced to zero at the end.
  assign rad  = RW'(head.diag) + ONE_R;
  assign sq_v = head.degenerate ? '0 : VW'({rad[RW-2:0], {FRAC_BITS{1'b0}}});

  assign sq_in.degenerate = head.degenerate;
  assign sq_in.slot       = head.slot;
  assign sq_in.d0         = head.d0;
  assign sq_in.d1         = head.d1;
  assign sq_in.d2         = head.d2;

  rmq_sqrt #(.VW(VW), .SIDE_W(SQS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (!qstat.empty),
    .in_v      (sq_v),
    .in_side   (sq_in),
    .out_valid (sq_valid),
    .out_root  (root),
    .out_side  (sq_out_bits)
  );

  assign sq_out = rmq_pkg::sq_side_t'(sq_out_bits);

  // The component taken straight from the root is half of it, saturated.
  assign half = MW'(root >> 1);
  assign dv_in.degenerate = sq_out.degenerate;
  assign dv_in.slot       = sq_out.slot;
  assign dv_in.main_val   = (half > MW'(32767)) ? rmq_pkg::Q_MAX : half[15:0];

  rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW), .SIDE_W(DVS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (sq_valid),
    .in_root   (root),
    .in_d      ({sq_out.d2, sq_out.d1, sq_out.d0}),
    .in_side   (dv_in),
    .out_valid (div_valid),
    .out_q     (lane_q),
    .out_side  (dv_out_bits)
  );

  assign dv_out = rmq_pkg::div_side_t'(dv_out_bits);

  // Put the root component in its slot and the three quotients around it.
  always_comb begin
    unique case (dv_out.slot)
      rmq_pkg::SLOT_W: begin
        quat_next.qw = dv_out.main_val;
        quat_next.qx = lane_q[0];
        quat_next.qy = lane_q[1];
        quat_next.qz = lane_q[2];
      end
      rmq_pkg::SLOT_X: begin
        quat_next.qw = lane_q[0];
        quat_next.qx = dv_out.main_val;
        quat_next.qy = lane_q[1];
        quat_next.qz = lane_q[2];
      end
      rmq_pkg::SLOT_Y: begin
        quat_next.qw = lane_q[0];
        quat_next.qx = lane_q[1];
        quat_next.qy = dv_out.main_val;
        quat_next.qz = lane_q[2];
      end
      rmq_pkg::SLOT_Z: begin
        quat_next.qw = lane_q[0];
        quat_next.qx = lane_q[1];
        quat_next.qy = lane_q[2];
        quat_next.qz = dv_out.main_val;
      end
    endcase
    quat_next.degenerate = dv_out.degenerate;
    if (dv_out.degenerate) begin
      quat_next.qw = '0;
      quat_next.qx = '0;
      quat_next.qy = '0;
      quat_next.qz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (back_en) begin
      quat_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      quat <= quat_next;
    end
  end

  // A degenerate beat carries an all-zero quaternion.
  `RMQ_ASSERT_NOW(a_degen_zero, clk, rst, quat_valid && quat.degenerate,
    quat.qw == 16'sd0 && quat.qx == 16'sd0 && quat.qy == 16'sd0 && quat.qz == 16'sd0)
  // A valid result never has all four components at zero: the root one is at least 64.
  `RMQ_ASSERT_NOW(a_root_nonzero, clk, rst, quat_valid && !quat.degenerate,
    quat.qw != 16'sd0 || quat.qx != 16'sd0 || quat.qy != 16'sd0 || quat.qz != 16'sd0)
  // A finished beat leaving the divider is shown on the output in the next cycle.
  `RMQ_ASSERT_NEXT(a_drain, clk, rst, div_valid && back_en, quat_valid)

endmodule

`default_nettype wire
